// ===== rtl/core/tns_pkg.sv =====
package tns_pkg;

  localparam int unsigned NOTE_DEPTH_DEF = 1024;
  localparam logic [31:0] REF_CLK_RST    = 32'd1193180;
  localparam logic [15:0] REST_PITCH_RST = 16'd59659;
  localparam logic [15:0] TONE_TICKS     = 16'hffff;

  typedef enum logic [2:0] {
    K_LOAD   = 3'd0,
    K_PLAY   = 3'd1,
    K_TONE   = 3'd2,
    K_PAUSE  = 3'd3,
    K_RESUME = 3'd4,
    K_STOP   = 3'd5,
    K_SEEK   = 3'd6,
    K_TICK   = 3'd7
  } kind_t;

  localparam logic [1:0] ST_STOPPED = 2'd0;
  localparam logic [1:0] ST_PLAYING = 2'd1;
  localparam logic [1:0] ST_PAUSED  = 2'd2;

  localparam logic CFG_REF_CLK    = 1'b0;
  localparam logic CFG_REST_PITCH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch input item
    logic exec;        // apply simple command update
    logic fetch;       // issue note read at fetch address
    logic fetch_seek;  // fetch address is the seek pointer
    logic start_chk;   // evaluate fetched note for start of note
    logic seek_init;   // init seek walk
    logic seek_step;   // evaluate one fetched note in the walk
    logic div_start;   // start divider with pending hz
    logic div_done_ld; // store quotient in divisor
    logic out_load;    // load output register
  } tns_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_fetch;  // command needs a note fetch
    logic is_seek;     // command is an owned seek
    logic seek_end;    // walk finished (found or end)
    logic div_req;     // a pitch must be sounded
    logic div_busy;
  } tns_sts_t;

endpackage

// ===== rtl/core/tns_div.sv =====
module tns_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] quot
);

  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [17:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[31]} - {2'b00, d_r};
    if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], q_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = q_r[15:0];

endmodule

// ===== rtl/core/tns_ctrl.sv =====
module tns_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tns_pkg::tns_sts_t   sts,
  output tns_pkg::tns_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FWAIT, S_FCHK, S_SWAIT, S_SCHK, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_seek) begin
          cmd.seek_init  = 1'b1;
          cmd.fetch      = 1'b1;
          cmd.fetch_seek = 1'b1;
          state_nxt      = S_SWAIT;
        end else if (sts.need_fetch) begin
          cmd.fetch = 1'b1;
          state_nxt = S_FWAIT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_FWAIT: state_nxt = S_FCHK;
      S_FCHK: begin
        cmd.start_chk = 1'b1;
        state_nxt     = S_DIV;
      end
      S_SWAIT: state_nxt = S_SCHK;
      S_SCHK: begin
        cmd.seek_step = 1'b1;
        if (sts.seek_end) begin
          state_nxt = S_DIV;
        end else begin
          cmd.fetch      = 1'b1;
          cmd.fetch_seek = 1'b1;
          state_nxt      = S_SWAIT;
        end
      end
      S_DIV: begin
        if (sts.div_req) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_OUT: begin
        if (!sts.div_busy) begin
          cmd.div_done_ld = 1'b1;
          cmd.out_load    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE) && !(out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  property p_ready_idle;
    @(posedge clk) disable iff (!rst_n) in_ready |-> state_r == S_IDLE;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

  property p_cap_exec;
    @(posedge clk) disable iff (!rst_n) cmd.capture |=> state_r == S_EXEC;
  endproperty
  a_cap_exec: assert property (p_cap_exec) else $error("capture not followed by exec");

  property p_divld;
    @(posedge clk) disable iff (!rst_n) cmd.div_done_ld |-> !sts.div_busy && cmd.out_load;
  endproperty
  a_divld: assert property (p_divld) else $error("quotient taken while busy");

endmodule

// ===== rtl/core/tns_dp.sv =====
module tns_dp #(
  parameter int unsigned NOTE_DEPTH = tns_pkg::NOTE_DEPTH_DEF,
  localparam int unsigned PW = ($clog2(NOTE_DEPTH) + 1 > 11) ? $clog2(NOTE_DEPTH) + 1 : 11,
  localparam int unsigned AW = $clog2(NOTE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tns_pkg::tns_cmd_t cmd,
  output tns_pkg::tns_sts_t sts,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [2:0]        in_kind,
  input  logic [7:0]        in_owner_id,
  input  logic [9:0]        in_note_index,
  input  logic [15:0]       in_pitch,
  input  logic [15:0]       in_duration,
  input  logic [31:0]       in_seek_ticks,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_speaker_on,
  output logic [15:0]       out_divisor,
  output logic              out_divisor_write,
  output logic [1:0]        out_play_state,
  output logic [9:0]        out_current_note,
  output logic [15:0]       out_ticks_left,
  output logic [31:0]       out_elapsed_ticks,
  output logic [7:0]        out_current_owner,
  output logic              out_owner_valid
);

  logic [31:0] ref_r;
  logic [15:0] rest_r;
  logic [31:0] mem [NOTE_DEPTH];
  logic [31:0] rd_r;
  logic        rd_vld_r;

  // captured item
  logic [2:0]  k_r;
  logic [7:0]  o_r;
  logic [9:0]  ix_r;
  logic [15:0] p_r, d_r;
  logic [31:0] sk_r;

  // architectural state
  logic [PW-1:0] start_r, ptr_r;
  logic          tmode_r, held_r, gate_r, wr_r;
  logic [15:0]   tpitch_r, left_r, div_r;
  logic [1:0]    st_r;
  logic [7:0]    own_r;
  logic [31:0]   el_r;

  // pending sound request and walk state
  logic          dreq_r;
  logic [15:0]   dhz_r;
  logic [32:0]   bef_r;

  // output register
  logic          ov_r;

  logic mine;
  assign mine = held_r && (own_r == o_r);

  // pointer the command moves to, so the fetch sees the new note
  logic [PW-1:0] nptr;
  always_comb begin
    nptr = ptr_r;
    case (tns_pkg::kind_t'(k_r))
      tns_pkg::K_PLAY: nptr = PW'(ix_r);
      tns_pkg::K_TONE: nptr = '0;
      tns_pkg::K_TICK: if (ptr_r < PW'(NOTE_DEPTH)) nptr = ptr_r + PW'(1);
      default: ;
    endcase
  end

  // note read with end-of-table and tone handling
  logic [PW-1:0] faddr;
  logic [15:0]   fp, fd;
  logic [PW-1:0] fptr_r;
  assign faddr = cmd.fetch_seek ? (cmd.seek_init ? start_r : fptr_r + PW'(1)) : nptr;
  always_comb begin
    fp = '0;
    fd = '0;
    if (tmode_r) begin
      if (fptr_r == '0) begin
        fp = tpitch_r;
        fd = tns_pkg::TONE_TICKS;
      end
    end else if (rd_vld_r) begin
      fp = rd_r[31:16];
      fd = rd_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_valid) begin
      if (cfg_index == tns_pkg::CFG_REF_CLK) ref_r <= cfg_data;
      else rest_r <= cfg_data[15:0];
    end
    if (!rst_n) begin
      ref_r  <= tns_pkg::REF_CLK_RST;
      rest_r <= tns_pkg::REST_PITCH_RST;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && k_r == tns_pkg::K_LOAD && PW'(ix_r) < PW'(NOTE_DEPTH))
      mem[AW'(ix_r)] <= {p_r, d_r};
    if (cmd.fetch) begin
      rd_r     <= mem[faddr[AW-1:0]];
      rd_vld_r <= (faddr < PW'(NOTE_DEPTH));
      fptr_r   <= faddr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      k_r  <= in_kind;
      o_r  <= in_owner_id;
      ix_r <= in_note_index;
      p_r  <= in_pitch;
      d_r  <= in_duration;
      sk_r <= in_seek_ticks;
    end
  end

  // divider
  logic        dv_busy;
  logic [15:0] dv_q;
  tns_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(ref_r), .divisor(dhz_r), .busy(dv_busy), .quot(dv_q)
  );

  logic [32:0] bsum;
  assign bsum = bef_r + {17'd0, fd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0; ptr_r <= '0; tmode_r <= 1'b0; tpitch_r <= '0;
      st_r <= tns_pkg::ST_STOPPED; own_r <= '0; held_r <= 1'b0;
      el_r <= '0; left_r <= '0; div_r <= '0; gate_r <= 1'b0; wr_r <= 1'b0;
      dreq_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        wr_r <= 1'b0; dreq_r <= 1'b0;
      end
      if (cmd.exec) begin
        case (tns_pkg::kind_t'(k_r))
          tns_pkg::K_PLAY, tns_pkg::K_TONE: begin
            tmode_r <= (k_r == tns_pkg::K_TONE);
            if (k_r == tns_pkg::K_TONE) tpitch_r <= p_r;
            start_r <= (k_r == tns_pkg::K_TONE) ? '0 : PW'(ix_r);
            ptr_r   <= (k_r == tns_pkg::K_TONE) ? '0 : PW'(ix_r);
            own_r <= o_r; held_r <= 1'b1; el_r <= '0;
            st_r <= tns_pkg::ST_PLAYING;
          end
          tns_pkg::K_PAUSE: if (mine && st_r == tns_pkg::ST_PLAYING) begin
            st_r <= tns_pkg::ST_PAUSED; dreq_r <= 1'b1; dhz_r <= rest_r;
          end
          tns_pkg::K_RESUME: if (mine && st_r == tns_pkg::ST_PAUSED) st_r <= tns_pkg::ST_PLAYING;
          tns_pkg::K_STOP: if (mine) begin
            st_r <= tns_pkg::ST_STOPPED; held_r <= 1'b0; own_r <= '0; tmode_r <= 1'b0;
            start_r <= '0; ptr_r <= '0; el_r <= '0; left_r <= '0; gate_r <= 1'b0;
          end
          tns_pkg::K_TICK: if (st_r == tns_pkg::ST_PLAYING) begin
            el_r   <= el_r + 32'd1;
            left_r <= left_r - 16'd1;
            if (left_r == 16'd1 && ptr_r < PW'(NOTE_DEPTH)) ptr_r <= ptr_r + PW'(1);
          end
          default: ;
        endcase
      end
      if (cmd.seek_init) begin
        bef_r <= '0;
      end
      if (cmd.seek_step) begin
        if (fd == 16'd0) begin
          // walked off the song end, seek ignored
        end else if (bsum > {1'b0, sk_r}) begin
          el_r   <= sk_r;
          ptr_r  <= fptr_r;
          left_r <= fd - 16'(sk_r - bef_r[31:0]);
          if (st_r == tns_pkg::ST_PLAYING) begin
            dreq_r <= 1'b1; dhz_r <= (fp != 16'd0) ? fp : rest_r;
          end
        end else begin
          bef_r <= bsum;
        end
      end
      if (cmd.start_chk) begin
        if (k_r == tns_pkg::K_RESUME) begin
          dreq_r <= 1'b1; dhz_r <= (fp != 16'd0) ? fp : rest_r;
        end else if (fd == 16'd0) begin
          st_r <= tns_pkg::ST_STOPPED; gate_r <= 1'b0;
        end else begin
          left_r <= fd;
          dreq_r <= 1'b1; dhz_r <= (fp != 16'd0) ? fp : rest_r;
        end
      end
      if (cmd.div_start && dhz_r == 16'd0) gate_r <= 1'b0;
      if (cmd.div_done_ld && dhz_r != 16'd0) begin
        div_r <= dv_q; wr_r <= 1'b1; gate_r <= 1'b1;
      end
      if (cmd.out_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // status flags decided from captured item and current state
  always_comb begin
    sts.need_fetch = 1'b0;
    sts.is_seek    = 1'b0;
    case (tns_pkg::kind_t'(k_r))
      tns_pkg::K_PLAY, tns_pkg::K_TONE: sts.need_fetch = 1'b1;
      tns_pkg::K_RESUME: sts.need_fetch = mine && st_r == tns_pkg::ST_PAUSED;
      tns_pkg::K_SEEK: sts.is_seek = mine;
      tns_pkg::K_TICK: sts.need_fetch = st_r == tns_pkg::ST_PLAYING && left_r == 16'd1;
      default: ;
    endcase
    sts.seek_end = (fd == 16'd0) || (bsum > {1'b0, sk_r});
    sts.div_req  = dreq_r;
    sts.div_busy = dv_busy;
  end

  assign out_valid         = ov_r;
  assign out_speaker_on    = gate_r;
  assign out_divisor       = div_r;
  assign out_divisor_write = wr_r;
  assign out_play_state    = st_r;
  assign out_current_note  = 10'(ptr_r);
  assign out_ticks_left    = left_r;
  assign out_elapsed_ticks = el_r;
  assign out_current_owner = own_r;
  assign out_owner_valid   = held_r;

endmodule

// ===== rtl/core/tone_note_sequencer.sv =====
// one result per item; a simple command goes through the exec and div states
// before its result is registered; a note fetch adds the fetch wait and check states
// a sounded pitch waits on the bit-serial divider (one quotient bit a cycle)
// seek walks the table one entry at a time through the single note memory read port
// items are taken one at a time; the next is accepted once the result is out
// synchronous active-low reset; the note table is not cleared
module tone_note_sequencer #(
  parameter int unsigned NOTE_DEPTH = tns_pkg::NOTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_owner_id,
  input  logic [9:0]  in_note_index,
  input  logic [15:0] in_pitch,
  input  logic [15:0] in_duration,
  input  logic [31:0] in_seek_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_speaker_on,
  output logic [15:0] out_divisor,
  output logic        out_divisor_write,
  output logic [1:0]  out_play_state,
  output logic [9:0]  out_current_note,
  output logic [15:0] out_ticks_left,
  output logic [31:0] out_elapsed_ticks,
  output logic [7:0]  out_current_owner,
  output logic        out_owner_valid
);

  tns_pkg::tns_cmd_t cmd;
  tns_pkg::tns_sts_t sts;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  tns_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  tns_dp #(.NOTE_DEPTH(NOTE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index[0]), .cfg_data(cfg_data),
    .in_kind(in_kind), .in_owner_id(in_owner_id), .in_note_index(in_note_index),
    .in_pitch(in_pitch), .in_duration(in_duration), .in_seek_ticks(in_seek_ticks),
    .out_ready(out_ready), .out_valid(out_valid),
    .out_speaker_on(out_speaker_on), .out_divisor(out_divisor),
    .out_divisor_write(out_divisor_write), .out_play_state(out_play_state),
    .out_current_note(out_current_note), .out_ticks_left(out_ticks_left),
    .out_elapsed_ticks(out_elapsed_ticks), .out_current_owner(out_current_owner),
    .out_owner_valid(out_owner_valid)
  );

endmodule

// ===== tb/tone_note_sequencer_tb.sv =====
module tone_note_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 20000;

  // one command as it goes into the block
  typedef struct {
    tns_pkg::kind_t kind;
    logic [7:0]  owner;
    logic [9:0]  index;
    logic [15:0] pitch;
    logic [15:0] dur;
    logic [31:0] seek;
  } command_t;

  // one player status as it comes out
  typedef struct {
    logic        spk;
    logic [15:0] div;
    logic        div_wr;
    logic [1:0]  pstate;
    logic [9:0]  note;
    logic [15:0] left;
    logic [31:0] elapsed;
    logic [7:0]  owner;
    logic        held;
  } status_t;

  // predicted player, everything but the note table so a trial run can be undone
  typedef struct {
    logic [9:0]  song_start;
    logic [10:0] ptr;
    logic        tone;
    logic [15:0] tone_pitch;
    logic [1:0]  pstate;
    logic [7:0]  owner;
    logic        held;
    logic [31:0] elapsed;
    logic [15:0] left;
    logic [15:0] div;
    logic        gate;
    logic        wrote;
  } player_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic [2:0] in_kind = '0;
  logic [7:0] in_owner_id = '0;
  logic [9:0] in_note_index = '0;
  logic [15:0] in_pitch = '0, in_duration = '0;
  logic [31:0] in_seek_ticks = '0;
  logic out_valid, out_ready = 1'b0;
  logic out_speaker_on, out_divisor_write, out_owner_valid;
  logic [15:0] out_divisor, out_ticks_left;
  logic [1:0] out_play_state;
  logic [9:0] out_current_note;
  logic [31:0] out_elapsed_ticks;
  logic [7:0] out_current_owner;

  tone_note_sequencer i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] note_tab [DEPTH];
  bit          note_written [DEPTH];
  player_t     plr;
  logic [31:0] ref_clk_hz;
  logic [15:0] rest_hz;
  int          unwritten_read;

  status_t     expected_status [$];
  int          fail_cnt, item_cnt, status_cnt, cfg_cnt, seek_cnt, wrap_cnt;
  int          burst_left, idle_cnt;
  int          stall_pct;

  // note fetch; end of table and past the tone read as an end mark
  task automatic read_note(input logic [10:0] p, output logic [15:0] pi, output logic [15:0] du);
    pi = '0;
    du = '0;
    if (plr.tone) begin
      if (p == 0) begin
        pi = plr.tone_pitch;
        du = tns_pkg::TONE_TICKS;
      end
    end else if (p < DEPTH) begin
      if (!note_written[p]) unwritten_read = p;
      {pi, du} = note_tab[p];
    end
  endtask

  task automatic sound(input logic [15:0] hz);
    logic [31:0] q;
    if (hz == 0) begin
      plr.gate = 1'b0;
    end else begin
      q = ref_clk_hz / {16'd0, hz};
      plr.div = q[15:0];
      plr.wrote = 1'b1;
      plr.gate = 1'b1;
    end
  endtask

  function automatic logic [15:0] audible(input logic [15:0] p);
    return (p != 0) ? p : rest_hz;
  endfunction

  task automatic start_note();
    logic [15:0] p, d;
    read_note(plr.ptr, p, d);
    if (d == 0) begin
      plr.pstate = tns_pkg::ST_STOPPED;
      sound(16'd0);
    end else begin
      plr.left = d;
      sound(audible(p));
    end
  endtask

  task automatic begin_song(input logic [9:0] start, input logic [7:0] own);
    plr.song_start = start;
    plr.ptr = {1'b0, start};
    plr.owner = own;
    plr.held = 1'b1;
    plr.elapsed = '0;
    plr.pstate = tns_pkg::ST_PLAYING;
    start_note();
  endtask

  // walk from song start to the note holding the offset; past the end is ignored
  task automatic seek_to(input logic [31:0] ticks);
    longint      acc;
    logic [10:0] p;
    logic [15:0] pi, du;
    acc = 0;
    p = {1'b0, plr.song_start};
    forever begin
      read_note(p, pi, du);
      if (du == 0) return;
      if (acc + du > ticks) break;
      acc += du;
      p++;
    end
    plr.elapsed = ticks;
    plr.ptr = p;
    plr.left = du - 16'(ticks - acc);
    if (plr.pstate == tns_pkg::ST_PLAYING) sound(audible(pi));
  endtask

  task automatic apply_command(input command_t c, output status_t s);
    logic        mine;
    logic [15:0] p, d;
    mine = plr.held && plr.owner == c.owner;
    plr.wrote = 1'b0;
    case (c.kind)
      tns_pkg::K_LOAD: begin
        note_tab[c.index] = {c.pitch, c.dur};
        note_written[c.index] = 1'b1;
      end
      tns_pkg::K_PLAY: begin
        plr.tone = 1'b0;
        begin_song(c.index, c.owner);
      end
      tns_pkg::K_TONE: begin
        plr.tone = 1'b1;
        plr.tone_pitch = c.pitch;
        begin_song('0, c.owner);
      end
      tns_pkg::K_PAUSE: if (mine && plr.pstate == tns_pkg::ST_PLAYING) begin
        plr.pstate = tns_pkg::ST_PAUSED;
        sound(rest_hz);
      end
      tns_pkg::K_RESUME: if (mine && plr.pstate == tns_pkg::ST_PAUSED) begin
        plr.pstate = tns_pkg::ST_PLAYING;
        read_note(plr.ptr, p, d);
        sound(audible(p));
      end
      tns_pkg::K_STOP: if (mine) begin
        plr.pstate = tns_pkg::ST_STOPPED;
        plr.held = 1'b0;
        plr.owner = '0;
        plr.tone = 1'b0;
        plr.song_start = '0;
        plr.ptr = '0;
        plr.elapsed = '0;
        plr.left = '0;
        sound(16'd0);
      end
      tns_pkg::K_SEEK: if (mine) seek_to(c.seek);
      default: if (plr.pstate == tns_pkg::ST_PLAYING) begin
        plr.elapsed++;
        plr.left--;
        if (plr.left == 0) begin
          if (plr.ptr < DEPTH) plr.ptr++;
          start_note();
        end
      end
    endcase
    s.spk = plr.gate;
    s.div = plr.div;
    s.div_wr = plr.wrote;
    s.pstate = plr.pstate;
    s.note = plr.ptr[9:0];
    s.left = plr.left;
    s.elapsed = plr.elapsed;
    s.owner = plr.owner;
    s.held = plr.held;
  endtask

  // sender: bursts of random length with random gaps between them
  task automatic send_command(input command_t c);
    status_t s;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_valid = 1'b1;
    in_kind = c.kind;
    in_owner_id = c.owner;
    in_note_index = c.index;
    in_pitch = c.pitch;
    in_duration = c.dur;
    in_seek_ticks = c.seek;
    do @(posedge clk); while (!in_ready);
    apply_command(c, s);
    expected_status.push_back(s);
    item_cnt++;
    if (c.kind == tns_pkg::K_SEEK) seek_cnt++;
  endtask

  function automatic command_t rand_fields(input tns_pkg::kind_t k);
    command_t c;
    c.kind = k;
    c.owner = 8'($urandom());
    c.index = 10'($urandom());
    c.pitch = 16'($urandom());
    c.dur = 16'($urandom());
    c.seek = $urandom();
    return c;
  endfunction

  // a command that would fetch a never-loaded entry gets that entry loaded first
  task automatic issue(input command_t c);
    player_t  saved;
    status_t  dummy;
    command_t fill;
    if (c.kind != tns_pkg::K_LOAD) begin
      forever begin
        saved = plr;
        unwritten_read = -1;
        apply_command(c, dummy);
        plr = saved;
        if (unwritten_read < 0) break;
        fill = rand_fields(tns_pkg::K_LOAD);
        fill.index = 10'(unwritten_read);
        fill.dur = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
        send_command(fill);
      end
    end
    send_command(c);
  endtask

  task automatic cmd(input tns_pkg::kind_t k, input logic [7:0] own, input logic [9:0] idx,
                     input logic [15:0] p, input logic [15:0] d, input logic [31:0] sk);
    command_t c;
    c = rand_fields(k);
    c.owner = own;
    c.index = idx;
    c.pitch = p;
    c.dur = d;
    c.seek = sk;
    issue(c);
  endtask

  // drop valid before waiting so the last item is not taken twice
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // register writes only while idle
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tns_pkg::CFG_REF_CLK) ref_clk_hz = val;
    else rest_hz = val[15:0];
    cfg_cnt++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver: stall probability is redrawn at random moments
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // compare each status transfer against the oldest prediction
  always @(posedge clk) begin
    status_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("status transfer with nothing expected");
        fail_cnt++;
      end else begin
        e = expected_status.pop_front();
        status_cnt++;
        check_field("speaker_on", e.spk, out_speaker_on);
        check_field("divisor", e.div, out_divisor);
        check_field("divisor_write", e.div_wr, out_divisor_write);
        check_field("play_state", e.pstate, out_play_state);
        check_field("current_note", e.note, out_current_note);
        check_field("ticks_left", e.left, out_ticks_left);
        check_field("elapsed_ticks", e.elapsed, out_elapsed_ticks);
        check_field("current_owner", e.owner, out_current_owner);
        check_field("owner_valid", e.held, out_owner_valid);
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("tone_note_sequencer_tb: FAIL");
      $finish;
    end
  end

  task automatic test_reset_state();
    cmd(tns_pkg::K_TICK, 8'h00, 10'd0, 16'h0, 16'h0, 32'h0);   // tick while stopped
    cmd(tns_pkg::K_PAUSE, 8'h00, 10'd0, 16'h0, 16'h0, 32'h0);  // no song held
    cmd(tns_pkg::K_SEEK, 8'h00, 10'd0, 16'h0, 16'h0, 32'h0);
  endtask

  task automatic test_song_play();
    cmd(tns_pkg::K_LOAD, 8'h11, 10'd0, 16'd440, 16'd2, '0);
    cmd(tns_pkg::K_LOAD, 8'h11, 10'd1, 16'd0, 16'd1, '0);          // rest
    cmd(tns_pkg::K_LOAD, 8'h11, 10'd2, 16'hffff, 16'd1, '0);
    cmd(tns_pkg::K_LOAD, 8'h11, 10'd3, 16'd1, 16'd0, '0);          // end mark
    cmd(tns_pkg::K_PLAY, 8'h11, 10'd0, '0, '0, '0);
    repeat (5) cmd(tns_pkg::K_TICK, 8'h00, '0, '0, '0, '0);        // runs to natural end
    cmd(tns_pkg::K_PLAY, 8'h11, 10'd3, '0, '0, '0);                // ends at once
  endtask

  task automatic test_table_end();
    cmd(tns_pkg::K_LOAD, 8'h22, 10'd1022, 16'd1000, 16'd1, '0);
    cmd(tns_pkg::K_LOAD, 8'h22, 10'd1023, 16'd2000, 16'hffff, '0);
    cmd(tns_pkg::K_PLAY, 8'hff, 10'd1022, '0, '0, '0);
    cmd(tns_pkg::K_SEEK, 8'hff, '0, '0, '0, 32'd65535);            // last tick of the table
    cmd(tns_pkg::K_TICK, 8'h00, '0, '0, '0, '0);
    cmd(tns_pkg::K_SEEK, 8'hff, '0, '0, '0, 32'hffff_ffff);        // past the end
  endtask

  task automatic test_tone_and_owner();
    cmd(tns_pkg::K_TONE, 8'h05, '0, 16'd0, '0, '0);                // tone of the rest pitch
    cmd(tns_pkg::K_PAUSE, 8'h06, '0, '0, '0, '0);                  // foreign owner
    cmd(tns_pkg::K_PAUSE, 8'h05, '0, '0, '0, '0);
    cmd(tns_pkg::K_PAUSE, 8'h05, '0, '0, '0, '0);                  // already paused
    cmd(tns_pkg::K_SEEK, 8'h05, '0, '0, '0, 32'd100);              // moves without sound
    cmd(tns_pkg::K_RESUME, 8'h05, '0, '0, '0, '0);
    cmd(tns_pkg::K_RESUME, 8'h05, '0, '0, '0, '0);                 // not paused
    cmd(tns_pkg::K_TONE, 8'h05, '0, 16'hffff, '0, '0);
    cmd(tns_pkg::K_STOP, 8'h07, '0, '0, '0, '0);                   // foreign stop ignored
    cmd(tns_pkg::K_STOP, 8'h05, '0, '0, '0, '0);
  endtask

  // mostly well-formed songs from a small table region, owners from a small pool
  task automatic test_random(input int n);
    command_t c;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) c = rand_fields(tns_pkg::K_TICK);
      else if (r < 55) c = rand_fields(tns_pkg::K_LOAD);
      else if (r < 63) c = rand_fields(tns_pkg::K_PLAY);
      else if (r < 67) c = rand_fields(tns_pkg::K_TONE);
      else if (r < 73) c = rand_fields(tns_pkg::K_PAUSE);
      else if (r < 79) c = rand_fields(tns_pkg::K_RESUME);
      else if (r < 82) c = rand_fields(tns_pkg::K_STOP);
      else if (r < 92) c = rand_fields(tns_pkg::K_SEEK);
      else c = rand_fields(tns_pkg::kind_t'($urandom_range(0, 7)));
      if ($urandom_range(0, 9) != 0) c.owner = 8'($urandom_range(0, 3));
      if ($urandom_range(0, 9) != 0) c.index = 10'($urandom_range(0, 63));
      if (c.kind == tns_pkg::K_LOAD && $urandom_range(0, 7) != 0)
        c.dur = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      if ($urandom_range(0, 3) != 0) c.pitch = 16'($urandom_range(0, 4000));
      if ($urandom_range(0, 5) != 0) c.seek = $urandom_range(0, 40);
      // tones run 65535 ticks; jump near their end so they wrap up
      if (plr.tone && c.kind == tns_pkg::K_SEEK && $urandom_range(0, 1) == 0) begin
        c.owner = plr.owner;
        c.seek = $urandom_range(65530, 65540);
        wrap_cnt++;
      end
      issue(c);
    end
  endtask

  initial begin
    ref_clk_hz = tns_pkg::REF_CLK_RST;
    rest_hz = tns_pkg::REST_PITCH_RST;
    plr = '{default: '0};
    plr.pstate = tns_pkg::ST_STOPPED;
    stall_pct = 0;
    foreach (note_written[i]) note_written[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_song_play();
    test_table_end();
    test_tone_and_owner();
    test_random(200);
    write_reg(tns_pkg::CFG_REF_CLK, 32'hffff_ffff);
    write_reg(tns_pkg::CFG_REST_PITCH, 32'd1);
    test_random(200);
    write_reg(tns_pkg::CFG_REF_CLK, 32'd1);
    write_reg(tns_pkg::CFG_REST_PITCH, 32'h0000_ffff);
    test_random(200);
    write_reg(tns_pkg::CFG_REF_CLK, $urandom());
    write_reg(tns_pkg::CFG_REST_PITCH, $urandom_range(1, 65535));
    test_random(250);

    wait_drained();
    repeat (50) @(posedge clk);
    $display("covered %0d commands (%0d seeks, %0d near tone end), %0d status transfers,",
             item_cnt, seek_cnt, wrap_cnt, status_cnt);
    $display("and %0d register writes across four clock and rest pitch settings", cfg_cnt);
    if (fail_cnt == 0 && expected_status.size() == 0) begin
      $display("tone_note_sequencer_tb: PASS");
    end else begin
      $display("tone_note_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
